// ===== src/ctwc_pkg.sv =====
package ctwc_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int COORD_W    = 10;
  localparam int FRAC_W     = 8;
  localparam int CENTROID_W = COORD_W + FRAC_W;
  localparam int SUM_W      = 30;
  localparam int COUNT_W    = 21;

  // Tracking constants
  localparam int MAX_DIM     = 1024;
  localparam int MIN_HITS    = 20;
  localparam int BOX_DIVISOR = 10;

  // Half-size of the search window: width / BOX_DIVISOR as a multiply by a
  // rounded-up reciprocal; exact for every width up to MAX_DIM
  localparam int BOX_SHIFT = 15;
  localparam int BOX_RECIP = (2 ** BOX_SHIFT + BOX_DIVISOR - 1) / BOX_DIVISOR;
  localparam int RECIP_W   = $clog2(BOX_RECIP + 1);
  localparam int HALF_W    = $clog2(MAX_DIM / BOX_DIVISOR + 1);
  localparam int SPAN_W    = HALF_W + FRAC_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = CENTROID_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W    = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RED_LOW      = 3'd0,
    REG_RED_HIGH     = 3'd1,
    REG_GREEN_LOW    = 3'd2,
    REG_GREEN_HIGH   = 3'd3,
    REG_BLUE_LOW     = 3'd4,
    REG_BLUE_HIGH    = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic                  pass;
    logic                  in_window;
    logic                  frame_done;
    logic [CENTROID_W-1:0] centroid_x;
    logic [CENTROID_W-1:0] centroid_y;
    logic [COUNT_W-1:0]    window_hits;
    logic                  used_fallback;
  } res_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_low;
    logic [PIX_W-1:0] red_high;
    logic [PIX_W-1:0] green_low;
    logic [PIX_W-1:0] green_high;
    logic [PIX_W-1:0] blue_low;
    logic [PIX_W-1:0] blue_high;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } cfg_t;

  // Classified pixel waiting for the back end
  typedef struct packed {
    logic               pass;
    logic               in_window;
    logic               frame_done;
    logic [COUNT_W-1:0] window_hits;
  } q_entry_t;

  // Sums chosen at the end of a frame
  typedef struct packed {
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [COUNT_W-1:0] count;
    logic               fallback;
    logic               keep;
  } fin_t;

  // Back end to front end
  typedef struct packed {
    logic [CENTROID_W-1:0] centroid_x;
    logic [CENTROID_W-1:0] centroid_y;
    logic                  resume;
  } ctr_t;

endpackage

// ===== src/ctwc_queue.sv =====
module ctwc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ctwc_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output ctwc_pkg::q_entry_t head,
  output logic               empty
);
  import ctwc_pkg::*;

  q_entry_t          store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue read while empty");

endmodule

// ===== src/ctwc_front.sv =====
module ctwc_front (
  input  logic               clk,
  input  logic               rst,
  input  ctwc_pkg::cfg_t     cfg,
  input  logic               push,
  output logic               full,
  input  ctwc_pkg::pix_t     pixel,
  input  ctwc_pkg::ctr_t     ctr,
  output logic               q_push,
  output ctwc_pkg::q_entry_t q_data,
  input  logic               q_full,
  output ctwc_pkg::fin_t     fin
);
  import ctwc_pkg::*;

  logic [COORD_W-1:0] column_count;
  logic [COORD_W-1:0] row_count;
  logic [SUM_W-1:0]   window_sum_x;
  logic [SUM_W-1:0]   window_sum_y;
  logic [COUNT_W-1:0] window_count;
  logic [SUM_W-1:0]   full_sum_x;
  logic [SUM_W-1:0]   full_sum_y;
  logic [COUNT_W-1:0] full_count;
  logic               hold_off;

  logic [DIM_W-1:0]         w_eff;
  logic [DIM_W-1:0]         h_eff;
  logic [DIM_W+RECIP_W-1:0] half_prod;
  logic [HALF_W-1:0]        half;
  logic [SPAN_W-1:0]        span;
  logic                     accept;
  logic                     pass;
  logic                     win;
  logic                     hit_win;
  logic                     row_end;
  logic                     done;
  logic [SUM_W-1:0]         add_x;
  logic [SUM_W-1:0]         add_y;
  logic [SUM_W-1:0]         window_sum_x_next;
  logic [SUM_W-1:0]         window_sum_y_next;
  logic [COUNT_W-1:0]       window_count_next;
  logic [SUM_W-1:0]         full_sum_x_next;
  logic [SUM_W-1:0]         full_sum_y_next;
  logic [COUNT_W-1:0]       full_count_next;
  fin_t                     fin_next;

  // Coordinate inside the clipped window around a Q10.8 centre
  function automatic logic coord_inside(
    input logic [COORD_W-1:0]    p,
    input logic [CENTROID_W-1:0] c,
    input logic [SPAN_W-1:0]     sp,
    input logic [DIM_W-1:0]      dim
  );
    logic [CENTROID_W-1:0] lo;
    logic [CENTROID_W:0]   hi;
    logic [CENTROID_W:0]   lim;
    lo  = (c > CENTROID_W'(sp)) ? (c - CENTROID_W'(sp)) : '0;
    hi  = (CENTROID_W+1)'(c) + (CENTROID_W+1)'(sp);
    lim = {dim, {FRAC_W{1'b0}}};
    if (hi > lim) begin
      hi = lim;
    end
    return (p >= lo[CENTROID_W-1:FRAC_W]) && ({1'b0, p, {FRAC_W{1'b0}}} < hi);
  endfunction

  // Clamp dimensions to 1..MAX_DIM
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (cfg.frame_width > DIM_W'(MAX_DIM)) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = cfg.frame_width;
    end
    if (cfg.frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (cfg.frame_height > DIM_W'(MAX_DIM)) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = cfg.frame_height;
    end
  end

  // Window half-size from the frame width
  assign half_prod = (DIM_W+RECIP_W)'(w_eff) * (DIM_W+RECIP_W)'(BOX_RECIP);
  assign half      = half_prod[BOX_SHIFT +: HALF_W];
  assign span      = {half, {FRAC_W{1'b0}}};

  // Classify the pixel
  assign full   = hold_off || q_full;
  assign accept = push && !full;

  assign pass = (pixel.red   >= cfg.red_low)   && (pixel.red   <= cfg.red_high)   &&
                (pixel.green >= cfg.green_low) && (pixel.green <= cfg.green_high) &&
                (pixel.blue  >= cfg.blue_low)  && (pixel.blue  <= cfg.blue_high);
  assign win  = coord_inside(column_count, ctr.centroid_x, span, w_eff) &&
                coord_inside(row_count, ctr.centroid_y, span, h_eff);
  assign hit_win = pass && win;

  assign row_end = (DIM_W'(column_count) + DIM_W'(1)) >= w_eff;
  assign done    = row_end && ((DIM_W'(row_count) + DIM_W'(1)) >= h_eff);

  // Accumulate sums with this pixel included
  assign add_x = SUM_W'(column_count);
  assign add_y = SUM_W'(row_count);

  assign full_sum_x_next   = pass    ? full_sum_x + add_x : full_sum_x;
  assign full_sum_y_next   = pass    ? full_sum_y + add_y : full_sum_y;
  assign full_count_next   = pass    ? full_count + COUNT_W'(1) : full_count;
  assign window_sum_x_next = hit_win ? window_sum_x + add_x : window_sum_x;
  assign window_sum_y_next = hit_win ? window_sum_y + add_y : window_sum_y;
  assign window_count_next = hit_win ? window_count + COUNT_W'(1) : window_count;

  // Choose window or full-frame sums at the end of the frame
  always_comb begin
    if (window_count_next > COUNT_W'(MIN_HITS)) begin
      fin_next.sum_x    = window_sum_x_next;
      fin_next.sum_y    = window_sum_y_next;
      fin_next.count    = window_count_next;
      fin_next.fallback = 1'b0;
      fin_next.keep     = 1'b0;
    end else begin
      fin_next.sum_x    = full_sum_x_next;
      fin_next.sum_y    = full_sum_y_next;
      fin_next.count    = full_count_next;
      fin_next.fallback = 1'b1;
      fin_next.keep     = (full_count_next == '0);
    end
  end

  // Hand the classified pixel to the queue
  assign q_push             = accept;
  assign q_data.pass        = pass;
  assign q_data.in_window   = win;
  assign q_data.frame_done  = done;
  assign q_data.window_hits = window_count_next;

  // Latch the chosen sums for the back end
  always_ff @(posedge clk) begin
    if (accept && done) begin
      fin <= fin_next;
    end
  end

  // Raster position, sums and end-of-frame hold
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      window_sum_x <= '0;
      window_sum_y <= '0;
      window_count <= '0;
      full_sum_x   <= '0;
      full_sum_y   <= '0;
      full_count   <= '0;
      hold_off     <= 1'b0;
    end else begin
      if (accept) begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= done ? '0 : row_count + COORD_W'(1);
        end else begin
          column_count <= column_count + COORD_W'(1);
        end
        if (done) begin
          window_sum_x <= '0;
          window_sum_y <= '0;
          window_count <= '0;
          full_sum_x   <= '0;
          full_sum_y   <= '0;
          full_count   <= '0;
          hold_off     <= 1'b1;
        end else begin
          window_sum_x <= window_sum_x_next;
          window_sum_y <= window_sum_y_next;
          window_count <= window_count_next;
          full_sum_x   <= full_sum_x_next;
          full_sum_y   <= full_sum_y_next;
          full_count   <= full_count_next;
        end
      end else if (ctr.resume) begin
        hold_off <= 1'b0;
      end
    end
  end

  a_sums_clear_while_held: assert property (@(posedge clk) disable iff (rst)
    hold_off |-> (full_count == '0) && (window_count == '0))
    else $error("sums not cleared while waiting for centroid");

endmodule

// ===== src/ctwc_div.sv =====
module ctwc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ctwc_pkg::SUM_W-1:0]        sum,
  input  logic [ctwc_pkg::COUNT_W-1:0]      count,
  output logic                              done,
  output logic [ctwc_pkg::CENTROID_W-1:0]   quot
);
  import ctwc_pkg::*;

  // Coordinates stay below 2^COORD_W, so sum < count * 2^COORD_W and the
  // quotient of (sum << FRAC_W) / count fits CENTROID_W bits. The upper
  // dividend bits therefore start as a remainder already below count.
  logic [COUNT_W-1:0]    rem;
  logic [CENTROID_W-1:0] bits;
  logic [DIV_CNT_W-1:0]  steps;
  logic                  running;
  logic [COUNT_W:0]      trial;
  logic                  take;

  assign trial = {rem, bits[CENTROID_W-1]};
  assign take  = (trial >= (COUNT_W+1)'(count));

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= COUNT_W'(sum[SUM_W-1:COORD_W]);
      bits <= {sum[COORD_W-1:0], {FRAC_W{1'b0}}};
      quot <= '0;
    end else if (running) begin
      rem  <= take ? COUNT_W'(trial - (COUNT_W+1)'(count)) : COUNT_W'(trial);
      bits <= {bits[CENTROID_W-2:0], 1'b0};
      quot <= {quot[CENTROID_W-2:0], take};
    end
  end

  // Step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps   <= '0;
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (steps == DIV_CNT_W'(1));
      if (start) begin
        steps   <= DIV_CNT_W'(DIV_STEPS);
        running <= 1'b1;
      end else if (running) begin
        steps   <= steps - DIV_CNT_W'(1);
        running <= (steps != DIV_CNT_W'(1));
      end
    end
  end

endmodule

// ===== src/ctwc_back.sv =====
module ctwc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  ctwc_pkg::q_entry_t q_data,
  output logic               q_pop,
  input  ctwc_pkg::fin_t     fin,
  output ctwc_pkg::ctr_t     ctr,
  input  logic               pop,
  output logic               empty,
  output ctwc_pkg::res_t     result
);
  import ctwc_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_DIV_X  = 4'b0010,
    B_DIV_Y  = 4'b0100,
    B_FINISH = 4'b1000
  } back_state_t;

  back_state_t           state;
  back_state_t           state_next;
  logic [CENTROID_W-1:0] centroid_x_reg;
  logic [CENTROID_W-1:0] centroid_y_reg;
  logic [CENTROID_W-1:0] quot_x;
  logic                  out_valid;
  res_t                  out_r;

  logic                  slot_free;
  logic                  load;
  res_t                  load_data;
  logic                  div_start;
  logic [SUM_W-1:0]      div_sum;
  logic                  div_done;
  logic [CENTROID_W-1:0] div_quot;
  logic                  resume;

  ctwc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (div_sum),
    .count (fin.count),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign result    = out_r;

  assign ctr.centroid_x = centroid_x_reg;
  assign ctr.centroid_y = centroid_y_reg;
  assign ctr.resume     = resume;

  // Sequence plain pixels and end-of-frame divisions
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    div_start  = 1'b0;
    div_sum    = fin.sum_x;
    resume     = 1'b0;

    load_data.pass          = q_data.pass;
    load_data.in_window     = q_data.in_window;
    load_data.frame_done    = q_data.frame_done;
    load_data.centroid_x    = centroid_x_reg;
    load_data.centroid_y    = centroid_y_reg;
    load_data.window_hits   = q_data.window_hits;
    load_data.used_fallback = 1'b0;

    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (!q_data.frame_done) begin
            if (slot_free) begin
              load  = 1'b1;
              q_pop = 1'b1;
            end
          end else if (fin.keep) begin
            state_next = B_FINISH;
          end else begin
            div_start  = 1'b1;
            state_next = B_DIV_X;
          end
        end
      end
      B_DIV_X: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_sum    = fin.sum_y;
          state_next = B_DIV_Y;
        end
      end
      B_DIV_Y: begin
        if (div_done) begin
          state_next = B_FINISH;
        end
      end
      B_FINISH: begin
        load_data.used_fallback = fin.fallback;
        if (slot_free) begin
          load       = 1'b1;
          q_pop      = 1'b1;
          resume     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      out_valid      <= 1'b0;
      centroid_x_reg <= '0;
      centroid_y_reg <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if ((state == B_DIV_Y) && div_done) begin
        centroid_x_reg <= quot_x;
        centroid_y_reg <= div_quot;
      end
    end
  end

  // Park the column quotient while the row divides
  always_ff @(posedge clk) begin
    if ((state == B_DIV_X) && div_done) begin
      quot_x <= div_quot;
    end
  end

  a_centroid_only_after_div: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (centroid_x_reg != $past(centroid_x_reg))) |->
    $past(state == B_DIV_Y)) else $error("centroid changed outside division");

  a_resume_with_frame_result: assert property (@(posedge clk) disable iff (rst)
    resume |=> out_valid && out_r.frame_done)
    else $error("front released without end-of-frame transfer");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == B_DIV_X) || (state == B_DIV_Y))
    else $error("division finished with nobody waiting");

endmodule

// ===== src/color_threshold_window_centroid_unit.sv =====
// Colour-threshold blob tracker with a search window around the last centroid.
// Pixels enter in raster order on the push/full side as one transfer each;
// every pixel gives exactly one result on the empty/pop side, in order.
// Each result carries the threshold outcome, the window test, the running
// window hit count and, on the last pixel of a frame, the new Q10.8 centroid.
// The APB port sets the colour bounds and the frame size; write it only while
// no pixel is in flight.
// A taken pixel is written into the queue and then loaded into the output
// register, from which its result is popped.
// Throughput: one pixel per cycle within a frame while the receiver keeps up,
// set by the four-entry queue between classifier and output stage. After the
// last pixel of a frame, full stays high until the centroid is updated: the
// shared divider produces one quotient bit per cycle, first for the column and
// then for the row, and the next frame's window needs the new centroid. A frame
// in which no pixel passed keeps the centroid and skips both divisions.
// Reset (synchronous) restores the default bounds and 320x240, clears the
// centroid, the raster position and the sums, and empties the queue.
// When the receiver stalls, results back up into the queue and full rises
// once it fills; nothing is dropped.
module color_threshold_window_centroid_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  ctwc_pkg::pix_t                pixel,
  output logic                          empty,
  input  logic                          pop,
  output ctwc_pkg::res_t                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctwc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ctwc_pkg::DATA_W-1:0]   pwdata,
  output logic [ctwc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ctwc_pkg::*;

  cfg_t     cfg;
  cfg_reg_t reg_idx;
  logic     cfg_write;
  ctr_t     ctr;
  fin_t     fin;
  q_entry_t q_in;
  q_entry_t q_head;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  assign pready    = 1'b1;
  assign reg_idx   = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_low      <= PIX_W'(0);
      cfg.red_high     <= PIX_W'(40);
      cfg.green_low    <= PIX_W'(0);
      cfg.green_high   <= PIX_W'(255);
      cfg.blue_low     <= PIX_W'(0);
      cfg.blue_high    <= PIX_W'(255);
      cfg.frame_width  <= DIM_W'(320);
      cfg.frame_height <= DIM_W'(240);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_RED_LOW:      cfg.red_low      <= pwdata[PIX_W-1:0];
        REG_RED_HIGH:     cfg.red_high     <= pwdata[PIX_W-1:0];
        REG_GREEN_LOW:    cfg.green_low    <= pwdata[PIX_W-1:0];
        REG_GREEN_HIGH:   cfg.green_high   <= pwdata[PIX_W-1:0];
        REG_BLUE_LOW:     cfg.blue_low     <= pwdata[PIX_W-1:0];
        REG_BLUE_HIGH:    cfg.blue_high    <= pwdata[PIX_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[DIM_W-1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      REG_RED_LOW:      prdata = DATA_W'(cfg.red_low);
      REG_RED_HIGH:     prdata = DATA_W'(cfg.red_high);
      REG_GREEN_LOW:    prdata = DATA_W'(cfg.green_low);
      REG_GREEN_HIGH:   prdata = DATA_W'(cfg.green_high);
      REG_BLUE_LOW:     prdata = DATA_W'(cfg.blue_low);
      REG_BLUE_HIGH:    prdata = DATA_W'(cfg.blue_high);
      REG_FRAME_WIDTH:  prdata = DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(cfg.frame_height);
      default:          prdata = '0;
    endcase
  end

  ctwc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .ctr    (ctr),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full),
    .fin    (fin)
  );

  ctwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ctwc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .fin     (fin),
    .ctr     (ctr),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== sim/tb_color_threshold_window_centroid_unit.sv =====
`timescale 1ns / 1ps

module tb_color_threshold_window_centroid_unit;
  import ctwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int RANDOM_PIXELS  = 700;
  localparam int MAX_PRINTS     = 40;
  localparam int PIX_BITS       = $bits(pix_t);

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              push    = 1'b0;
  logic              full;
  pix_t              pixel   = '0;
  logic              empty;
  logic              pop     = 1'b0;
  res_t              result;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  color_threshold_window_centroid_unit uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pixels waiting to be sent and results waiting to be seen
  pix_t pixel_backlog[$];
  res_t expected_results[$];
  int   mismatches = 0;

  // Tracker model state: bounds, frame size, centroid, raster position, sums
  cfg_t                  tracker_cfg;
  logic [CENTROID_W-1:0] track_cx, track_cy;
  int unsigned           raster_col, raster_row;
  longint unsigned       win_sum_x, win_sum_y, frame_sum_x, frame_sum_y;
  int unsigned           win_hits, frame_hits;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Zero acts as one, anything past the largest frame is clamped
  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // One axis of the search window, edges in Q10.8 and clipped to the frame
  function automatic bit in_span(int unsigned p, logic [CENTROID_W-1:0] c,
                                 int unsigned half, int unsigned dim);
    longint unsigned span, lo, hi, lim, pos;
    span = longint'(half) << FRAC_W;
    pos  = p;
    lo   = (c > span) ? c - span : 0;
    hi   = c + span;
    lim  = longint'(dim) << FRAC_W;
    if (hi > lim) hi = lim;
    return (pos >= (lo >> FRAC_W)) && ((pos << FRAC_W) < hi);
  endfunction

  function automatic logic [CENTROID_W-1:0] q_divide(longint unsigned sum, int unsigned count);
    longint unsigned quot;
    if (count == 0) return '0;
    quot = (sum << FRAC_W) / count;
    return quot[CENTROID_W-1:0];
  endfunction

  // Classify one pixel, advance the raster and update the centroid at frame end
  function automatic res_t predict_pixel(pix_t px);
    int unsigned w, h, half, x, y;
    bit          ok, win, row_end, done;
    res_t        r;
    w    = clamp_dim(tracker_cfg.frame_width);
    h    = clamp_dim(tracker_cfg.frame_height);
    half = w / BOX_DIVISOR;
    x    = raster_col;
    y    = raster_row;
    ok   = px.red >= tracker_cfg.red_low && px.red <= tracker_cfg.red_high &&
           px.green >= tracker_cfg.green_low && px.green <= tracker_cfg.green_high &&
           px.blue >= tracker_cfg.blue_low && px.blue <= tracker_cfg.blue_high;
    win  = in_span(x, track_cx, half, w) && in_span(y, track_cy, half, h);
    r    = '0;
    if (ok) begin
      frame_sum_x += x;
      frame_sum_y += y;
      frame_hits++;
      if (win) begin
        win_sum_x += x;
        win_sum_y += y;
        win_hits++;
      end
    end
    r.window_hits = win_hits[COUNT_W-1:0];
    row_end = (x + 1 >= w);
    done    = row_end && (y + 1 >= h);
    if (row_end) begin
      raster_col = 0;
      raster_row = done ? 0 : y + 1;
    end else begin
      raster_col = x + 1;
    end
    if (done) begin
      if (win_hits > MIN_HITS) begin
        track_cx = q_divide(win_sum_x, win_hits);
        track_cy = q_divide(win_sum_y, win_hits);
      end else begin
        r.used_fallback = 1'b1;
        if (frame_hits != 0) begin
          track_cx = q_divide(frame_sum_x, frame_hits);
          track_cy = q_divide(frame_sum_y, frame_hits);
        end
      end
      win_sum_x   = 0;
      win_sum_y   = 0;
      win_hits    = 0;
      frame_sum_x = 0;
      frame_sum_y = 0;
      frame_hits  = 0;
    end
    r.pass       = ok;
    r.in_window  = win;
    r.frame_done = done;
    r.centroid_x = track_cx;
    r.centroid_y = track_cy;
    return r;
  endfunction

  task automatic check_result(res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no pixel outstanding", got, 0);
      return;
    end
    want = expected_results.pop_front();
    if (got.pass !== want.pass) report_mismatch("pass", got.pass, want.pass);
    if (got.in_window !== want.in_window)
      report_mismatch("in_window", got.in_window, want.in_window);
    if (got.frame_done !== want.frame_done)
      report_mismatch("frame_done", got.frame_done, want.frame_done);
    if (got.centroid_x !== want.centroid_x)
      report_mismatch("centroid_x", got.centroid_x, want.centroid_x);
    if (got.centroid_y !== want.centroid_y)
      report_mismatch("centroid_y", got.centroid_y, want.centroid_y);
    if (got.window_hits !== want.window_hits)
      report_mismatch("window_hits", got.window_hits, want.window_hits);
    if (got.used_fallback !== want.used_fallback)
      report_mismatch("used_fallback", got.used_fallback, want.used_fallback);
  endtask

  // Sender: take pixels from the backlog, hold each until it transfers
  int send_gap    = 0;
  int send_count  = 0;
  bit send_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_pixel(pixel));
        send_count++;
        if (send_count % 32 == 0) send_steady = ($urandom_range(0, 2) == 0);
        send_gap = send_steady ? 0 : $urandom_range(0, 6);
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (pixel_backlog.size() != 0) begin
          pixel <= pixel_backlog.pop_front();
          push  <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer, then stall for a random number of cycles
  int take_gap    = 0;
  int take_count  = 0;
  bit take_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      take_gap = 0;
    end else begin
      if (pop && !empty) begin
        check_result(result);
        take_count++;
        if (take_count % 32 == 0) take_steady = ($urandom_range(0, 2) == 0);
        take_gap = take_steady ? 0 : $urandom_range(0, 6);
      end
      if (take_gap > 0) begin
        pop <= 1'b0;
        take_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_color_threshold_window_centroid_unit: errors");
        $finish;
      end
    end
  end

  // Write one register, mirror it in the model, then read it back
  task automatic cfg_write(cfg_reg_t idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RED_LOW:      tracker_cfg.red_low      = value[PIX_W-1:0];
      REG_RED_HIGH:     tracker_cfg.red_high     = value[PIX_W-1:0];
      REG_GREEN_LOW:    tracker_cfg.green_low    = value[PIX_W-1:0];
      REG_GREEN_HIGH:   tracker_cfg.green_high   = value[PIX_W-1:0];
      REG_BLUE_LOW:     tracker_cfg.blue_low     = value[PIX_W-1:0];
      REG_BLUE_HIGH:    tracker_cfg.blue_high    = value[PIX_W-1:0];
      REG_FRAME_WIDTH:  tracker_cfg.frame_width  = value[DIM_W-1:0];
      REG_FRAME_HEIGHT: tracker_cfg.frame_height = value[DIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) report_mismatch($sformatf("register %s", idx.name()), readback, value);
  endtask

  task automatic set_bounds(int rl, int rh, int gl, int gh, int bl, int bh);
    cfg_write(REG_RED_LOW, rl);
    cfg_write(REG_RED_HIGH, rh);
    cfg_write(REG_GREEN_LOW, gl);
    cfg_write(REG_GREEN_HIGH, gh);
    cfg_write(REG_BLUE_LOW, bl);
    cfg_write(REG_BLUE_HIGH, bh);
  endtask

  task automatic set_frame(int w, int h);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
  endtask

  // Hold until every pixel has gone and every result has come, then idle on
  task automatic wait_drain(int extra);
    while (pixel_backlog.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic add_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    pixel_backlog.push_back(p);
  endtask

  function automatic logic [PIX_W-1:0] chan_in(logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi);
    if (lo <= hi) return PIX_W'($urandom_range(hi, lo));
    return PIX_W'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] chan_out(logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi);
    if (lo > 0 && (hi == 8'hFF || $urandom_range(0, 1) == 0))
      return PIX_W'($urandom_range(lo - 1, 0));
    if (hi < 8'hFF) return PIX_W'($urandom_range(255, hi + 1));
    return chan_in(lo, hi);
  endfunction

  function automatic pix_t pass_pixel();
    pix_t p;
    p.red   = chan_in(tracker_cfg.red_low, tracker_cfg.red_high);
    p.green = chan_in(tracker_cfg.green_low, tracker_cfg.green_high);
    p.blue  = chan_in(tracker_cfg.blue_low, tracker_cfg.blue_high);
    return p;
  endfunction

  // Background pixel: push one channel out of its bounds where it can be
  function automatic pix_t fail_pixel();
    pix_t p;
    p = pass_pixel();
    case ($urandom_range(0, 2))
      0:       p.red   = chan_out(tracker_cfg.red_low, tracker_cfg.red_high);
      1:       p.green = chan_out(tracker_cfg.green_low, tracker_cfg.green_high);
      default: p.blue  = chan_out(tracker_cfg.blue_low, tracker_cfg.blue_high);
    endcase
    return p;
  endfunction

  // One frame with a blob of passing pixels on a failing background;
  // pause_at stops the sender mid-frame until the block has drained
  task automatic queue_frame(int w, int h, int bx, int by, int bw, int bh, int pause_at);
    bit in_blob;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (y * w + x == pause_at) wait_drain(0);
        in_blob = x >= bx && x < bx + bw && y >= by && y < by + bh;
        if (in_blob && $urandom_range(0, 15) != 0)
          pixel_backlog.push_back(pass_pixel());
        else if ($urandom_range(0, 9) == 0)
          pixel_backlog.push_back(pix_t'(PIX_BITS'($urandom)));
        else
          pixel_backlog.push_back(fail_pixel());
      end
    end
  endtask

  task automatic random_bounds();
    int lo, hi;
    for (int ch = 0; ch < 3; ch++) begin
      lo = $urandom_range(0, 100);
      hi = $urandom_range(150, 255);
      if ($urandom_range(0, 5) == 0) lo = 0;
      if ($urandom_range(0, 5) == 0) hi = 255;
      // Now and then make a channel impossible so nothing passes
      if ($urandom_range(0, 11) == 0) begin
        lo = $urandom_range(150, 255);
        hi = $urandom_range(0, 100);
      end
      cfg_write(cfg_reg_t'(REG_RED_LOW + 2 * ch), lo);
      cfg_write(cfg_reg_t'(REG_RED_HIGH + 2 * ch), hi);
    end
  endtask

  initial begin
    int w, h, bw, bh, bx, by, frames, pick, queued;
    bit split_done;

    // Model starts from the reset values of the block
    tracker_cfg = '{red_low: 8'd0, red_high: 8'd40, green_low: 8'd0, green_high: 8'd255,
                    blue_low: 8'd0, blue_high: 8'd255, frame_width: 11'd320,
                    frame_height: 11'd240};
    track_cx    = '0;
    track_cy    = '0;
    raster_col  = 0;
    raster_row  = 0;
    win_sum_x   = 0;
    win_sum_y   = 0;
    win_hits    = 0;
    frame_sum_x = 0;
    frame_sum_y = 0;
    frame_hits  = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero-sized frame acts as one pixel: every pixel ends a frame
    set_bounds(0, 255, 0, 255, 0, 255);
    set_frame(0, 0);
    add_pixel(8'h00, 8'h00, 8'h00);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'hAA, 8'h55, 8'hAA);
    wait_drain(SETTLE_CYCLES);

    // Tight bounds: one pixel on each edge, the rest miss and keep the centroid
    set_bounds(255, 255, 0, 0, 128, 128);
    add_pixel(8'hFF, 8'h00, 8'h80);
    add_pixel(8'hFE, 8'h00, 8'h80);
    add_pixel(8'hFF, 8'h01, 8'h80);
    add_pixel(8'hFF, 8'h00, 8'h7F);
    add_pixel(8'hFF, 8'h00, 8'h81);
    add_pixel(8'h00, 8'hFF, 8'hFF);
    wait_drain(SETTLE_CYCLES);

    // Oversized frame, then shrink it mid-frame so the row and the frame end
    set_bounds(0, 255, 0, 255, 0, 255);
    set_frame(2047, 2047);
    repeat (4) pixel_backlog.push_back(pix_t'(PIX_BITS'($urandom)));
    wait_drain(0);
    cfg_write(REG_FRAME_WIDTH, 2);
    add_pixel(8'h12, 8'h34, 8'h56);
    wait_drain(0);
    cfg_write(REG_FRAME_HEIGHT, 1);
    add_pixel(8'h80, 8'h01, 8'hFE);
    add_pixel(8'h7F, 8'hFE, 8'h01);
    wait_drain(SETTLE_CYCLES);

    // Random phases: new bounds and frame size, a few frames around one blob
    queued     = 0;
    split_done = 1'b0;
    while (queued < RANDOM_PIXELS) begin
      random_bounds();
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        w = $urandom_range(30, 34);
        h = $urandom_range(7, 8);
      end else if (pick < 8) begin
        w = $urandom_range(20, 29);
        h = $urandom_range(5, 7);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 5);
      end
      set_frame(w, h);
      bw = $urandom_range(5, 7);
      bh = $urandom_range(4, 6);
      if (bw > w) bw = w;
      if (bh > h) bh = h;
      bx = $urandom_range(0, w - bw);
      by = $urandom_range(0, h - bh);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        // Stop adding frames once the pixel budget is reached
        if (queued < RANDOM_PIXELS) begin
          queue_frame(w, h, bx, by, bw, bh, split_done ? -1 : (w * h) / 2);
          split_done = 1'b1;
          queued += w * h;
        end
      end
      wait_drain(SETTLE_CYCLES);
    end

    if (mismatches == 0)
      $display("tb_color_threshold_window_centroid_unit: clean");
    else
      $display("tb_color_threshold_window_centroid_unit: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ctwc_pkg.sv
src/ctwc_queue.sv
src/ctwc_front.sv
src/ctwc_div.sv
src/ctwc_back.sv
src/color_threshold_window_centroid_unit.sv
sim/tb_color_threshold_window_centroid_unit.sv
